// ===== hdl/wwsm_pkg.sv =====
// Shared constants, register codes and types of the whole-word substring matcher.
package wwsm_pkg;

	localparam int PATTERN_MAX_DEF = 8;
	localparam int LINE_MAX_DEF    = 4096;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_W      = 4;
	localparam int LINE_W     = 24;
	localparam int COL_W      = 12;
	localparam int TOTAL_W    = 24;

	localparam logic [LINE_W-1:0]  LINE_SAT  = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_CASE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WHOLE_WORD = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_MAP_0 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_MAP_1 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_MAP_2 = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_MAP_3 = 4'd7;

	// Default word characters: digits in map 0; letters and underscore in map 1.
	localparam logic [63:0] WORD_MAP_0_RST = 64'd287948901175001088;
	localparam logic [63:0] WORD_MAP_1_RST = 64'd576460745995190270;

	typedef struct packed {
		logic [63:0]      pattern;
		logic [LEN_W-1:0] pat_len;     // already limited to 1..PATTERN_MAX
		logic             match_case;
		logic             whole_word;
		logic [255:0]     word_map;
	} cfg_t;

endpackage

// ===== hdl/wwsm_text_if.sv =====
// Text channel: one byte or one line-end marker per word.
interface wwsm_text_if;
	import wwsm_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       line_end;

	modport source (output valid, output text_byte, output line_end, input ready);
	modport sink (input valid, input text_byte, input line_end, output ready);
endinterface

// ===== hdl/wwsm_match_if.sv =====
// Match channel: line, start column and running total of one accepted match.
interface wwsm_match_if;
	import wwsm_pkg::*;

	logic               valid;
	logic               ready;
	logic [LINE_W-1:0]  match_line;
	logic [COL_W-1:0]   match_column;
	logic [TOTAL_W-1:0] match_total;

	modport source (output valid, output match_line, output match_column,
		output match_total, input ready);
	modport sink (input valid, input match_line, input match_column,
		input match_total, output ready);
endinterface

// ===== hdl/wwsm_cfg_regs.sv =====
// Configuration register file of the matcher, with pattern length limiting.
module wwsm_cfg_regs #(
	parameter int PATTERN_MAX = wwsm_pkg::PATTERN_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wwsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wwsm_pkg::CFG_DATA_W-1:0] cfg_data,
	output wwsm_pkg::cfg_t                  cfg
);
	import wwsm_pkg::*;

	logic [63:0]      pattern_q;
	logic [LEN_W-1:0] pat_len_q;
	logic             match_case_q;
	logic             whole_word_q;
	logic [63:0]      map0_q, map1_q, map2_q, map3_q;
	logic [LEN_W-1:0] len_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q    <= '0;
			pat_len_q    <= LEN_W'(1);
			match_case_q <= 1'b0;
			whole_word_q <= 1'b0;
			map0_q       <= WORD_MAP_0_RST;
			map1_q       <= WORD_MAP_1_RST;
			map2_q       <= '0;
			map3_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN:    pattern_q    <= cfg_data;
				REG_PAT_LEN:    pat_len_q    <= cfg_data[LEN_W-1:0];
				REG_MATCH_CASE: match_case_q <= cfg_data[0];
				REG_WHOLE_WORD: whole_word_q <= cfg_data[0];
				REG_WORD_MAP_0: map0_q       <= cfg_data;
				REG_WORD_MAP_1: map1_q       <= cfg_data;
				REG_WORD_MAP_2: map2_q       <= cfg_data;
				REG_WORD_MAP_3: map3_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// A length of zero behaves as one; anything above the window behaves as full width.
	always_comb begin
		if (pat_len_q == '0) begin
			len_lim = LEN_W'(1);
		end else if (pat_len_q > LEN_W'(PATTERN_MAX)) begin
			len_lim = LEN_W'(PATTERN_MAX);
		end else begin
			len_lim = pat_len_q;
		end
	end

	assign cfg.pattern    = pattern_q;
	assign cfg.pat_len    = len_lim;
	assign cfg.match_case = match_case_q;
	assign cfg.whole_word = whole_word_q;
	assign cfg.word_map   = {map3_q, map2_q, map1_q, map0_q};

endmodule

// ===== hdl/whole_word_substring_matcher.sv =====
// Top level of the whole-word substring matcher: window compare and result register.
// A word accepted into the input stage is scanned there and any match it gives is
// loaded into the result register when that stage advances, to be taken from there.
// Throughput: one text word per cycle while the match side takes results as they come.
// A pending whole-word candidate is reported if the next word is no word character.
// Reset (arst_n low): registers to defaults, line count 1, scan state and valids 0.
module whole_word_substring_matcher #(
	parameter int PATTERN_MAX = wwsm_pkg::PATTERN_MAX_DEF,
	parameter int LINE_MAX    = wwsm_pkg::LINE_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wwsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wwsm_pkg::CFG_DATA_W-1:0] cfg_data,
	wwsm_text_if.sink                       text,
	wwsm_match_if.source                    result
);
	import wwsm_pkg::*;

	localparam int WIN_IDX_W = $clog2(PATTERN_MAX + 1);
	localparam int SKIP_W    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int COL_LIM_I = ((LINE_MAX - 1) > 4095) ? 4095 : (LINE_MAX - 1);
	localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COL_LIM_I);

	cfg_t cfg;

	wwsm_cfg_regs #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	function automatic logic [7:0] fold(input logic [7:0] b, input logic exact);
		logic [7:0] r;
		r = b;
		if (!exact && b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'd32;
		end
		return r;
	endfunction

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eol_s1;
	logic       adv;

	// Scan state
	logic [7:0]         recent_q [PATTERN_MAX];
	logic [SKIP_W-1:0]  skip_q;
	logic [COL_W-1:0]   col_q;
	logic [LINE_W-1:0]  line_q;
	logic               pend_q;
	logic [COL_W-1:0]   pcol_q;
	logic [TOTAL_W-1:0] total_q;

	// Result register
	logic               out_valid_q;
	logic [LINE_W-1:0]  out_line_q;
	logic [COL_W-1:0]   out_col_q;
	logic [TOTAL_W-1:0] out_total_q;

	// Next-state values
	logic [7:0]         win_new [PATTERN_MAX + 1];
	logic [7:0]         recent_d [PATTERN_MAX];
	logic               cmp_ok, can_end, hit, left_ok, emit_pend, emit;
	logic [COL_W-1:0]   start_col, emit_col, col_d, pcol_d;
	logic [SKIP_W-1:0]  skip_d;
	logic [LINE_W-1:0]  line_d;
	logic [TOTAL_W-1:0] total_d;
	logic               pend_d;
	logic [7:0]         left_byte;

	assign adv        = valid_s1 && (!out_valid_q || result.ready);
	assign text.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			eol_s1  <= text.line_end;
		end
	end

	always_comb begin
		win_new[0] = byte_s1;
		for (int j = 1; j <= PATTERN_MAX; j++) begin
			win_new[j] = recent_q[j-1];
		end

		emit_pend = pend_q && (eol_s1 || !cfg.whole_word
			|| !cfg.word_map[fold(byte_s1, cfg.match_case)]);

		// Pattern byte i lines up with the byte that arrived len-1-i words ago.
		cmp_ok = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (i < int'(cfg.pat_len)) begin
				if (fold(cfg.pattern[8*i +: 8], cfg.match_case)
					!= fold(win_new[WIN_IDX_W'(int'(cfg.pat_len) - 1 - i)],
					cfg.match_case)) begin
					cmp_ok = 1'b0;
				end
			end
		end

		can_end   = (skip_q == '0)
			&& (({1'b0, col_q} + (COL_W+1)'(1)) >= (COL_W+1)'(cfg.pat_len));
		hit       = !eol_s1 && can_end && cmp_ok;
		start_col = col_q - (COL_W'(cfg.pat_len) - COL_W'(1));
		left_byte = win_new[WIN_IDX_W'(cfg.pat_len)];
		left_ok   = (start_col == '0) || !cfg.word_map[fold(left_byte, cfg.match_case)];

		pend_d   = 1'b0;
		pcol_d   = pcol_q;
		emit     = emit_pend;
		emit_col = pcol_q;
		if (hit) begin
			if (cfg.whole_word) begin
				if (left_ok) begin
					pend_d = 1'b1;
					pcol_d = start_col;
				end
			end else if (!emit_pend) begin
				emit     = 1'b1;
				emit_col = start_col;
			end else begin
				// The earlier candidate goes out now; this one waits a word.
				pend_d = 1'b1;
				pcol_d = start_col;
			end
		end

		if (eol_s1) begin
			skip_d = '0;
		end else if (skip_q != '0) begin
			skip_d = skip_q - SKIP_W'(1);
		end else if (hit) begin
			skip_d = SKIP_W'(cfg.pat_len - LEN_W'(1));
		end else begin
			skip_d = skip_q;
		end

		if (eol_s1) begin
			col_d = '0;
		end else if (col_q < COL_LIMIT) begin
			col_d = col_q + COL_W'(1);
		end else begin
			col_d = col_q;
		end

		line_d  = (eol_s1 && line_q != LINE_SAT) ? line_q + LINE_W'(1) : line_q;
		total_d = (emit && total_q != TOTAL_SAT) ? total_q + TOTAL_W'(1) : total_q;

		for (int j = 0; j < PATTERN_MAX; j++) begin
			recent_d[j] = eol_s1 ? 8'd0 : win_new[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < PATTERN_MAX; j++) begin
				recent_q[j] <= 8'd0;
			end
			skip_q  <= '0;
			col_q   <= '0;
			line_q  <= LINE_W'(1);
			pend_q  <= 1'b0;
			pcol_q  <= '0;
			total_q <= '0;
		end else if (adv) begin
			recent_q <= recent_d;
			skip_q   <= skip_d;
			col_q    <= col_d;
			line_q   <= line_d;
			pend_q   <= pend_d;
			pcol_q   <= pcol_d;
			total_q  <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_line_q  <= line_q;
			out_col_q   <= emit_col;
			out_total_q <= total_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.match_line   = out_line_q;
	assign result.match_column = out_col_q;
	assign result.match_total  = out_total_q;

	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_total_q != '0)
		else $error("match reported with a zero running total");

	a_skip_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(skip_q) < PATTERN_MAX)
		else $error("skip count beyond the pattern window");

	a_pend_column: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> col_q != '0)
		else $error("candidate pending at the start of a line");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("input stage word lost while stalled");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line counter reached zero");

endmodule

// ===== sim/tb_whole_word_substring_matcher.sv =====
// Self-checking testbench of the whole-word substring matcher with a cycle-free match predictor.
module tb_whole_word_substring_matcher;
	import wwsm_pkg::*;

	localparam int WIN_DEPTH      = 9;
	localparam int COL_LIMIT      = (LINE_MAX_DEF - 1 > 4095) ? 4095 : LINE_MAX_DEF - 1;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS    = 150;
	localparam int RANDOM_PHASES  = 8;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       line_end;
	} text_word_t;

	typedef struct {
		logic [LINE_W-1:0]  line_no;
		logic [COL_W-1:0]   column;
		logic [TOTAL_W-1:0] total;
	} match_rec_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wwsm_text_if  text_ch();
	wwsm_match_if match_ch();

	whole_word_substring_matcher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text      (text_ch),
		.result    (match_ch)
	);

	always #4 clk = ~clk;

	// Register copies used by the predictor.
	logic [63:0]      cfg_pattern;
	logic [LEN_W-1:0] cfg_len;
	logic             cfg_case;
	logic             cfg_whole;
	logic [255:0]     cfg_word_map;

	// Scan state of the predictor.
	logic [7:0]         win_bytes [WIN_DEPTH];
	int unsigned        skip_left;
	int unsigned        col_count;
	logic [LINE_W-1:0]  line_count;
	bit                 cand_waiting;
	int unsigned        cand_col;
	logic [TOTAL_W-1:0] match_count;

	text_word_t text_queue[$];
	match_rec_t expected_matches[$];

	int send_idle_pct;
	int stall_pct;
	bit text_fire;
	int error_count;
	int words_taken;
	int matches_checked;
	int settings_count;
	int idle_cycles;

	int idle_send_tab[4]  = '{0, 87, 0, 20};
	int idle_stall_tab[4] = '{0, 0, 87, 20};

	function automatic logic [7:0] fold_case(input logic [7:0] b);
		if (!cfg_case && b >= "A" && b <= "Z") begin
			return b + 8'd32;
		end
		return b;
	endfunction

	function automatic bit is_word_char(input logic [7:0] b);
		logic [7:0] f;
		f = fold_case(b);
		return cfg_word_map[f];
	endfunction

	function automatic int unsigned eff_len();
		if (cfg_len == 0) begin
			return 1;
		end
		if (cfg_len > PATTERN_MAX_DEF) begin
			return PATTERN_MAX_DEF;
		end
		return cfg_len;
	endfunction

	function automatic logic [7:0] flip_case(input logic [7:0] b);
		if (b >= "A" && b <= "Z") begin
			return b + 8'd32;
		end
		if (b >= "a" && b <= "z") begin
			return b - 8'd32;
		end
		return b;
	endfunction

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0: return "a";
			1: return "b";
			2: return "A";
			3: return "B";
			4: return "_";
			5: return "1";
			6: return " ";
			7: return "-";
			8: return 8'($urandom_range(0, 255));
			default: return $urandom_range(0, 1) ? 8'hFF : 8'h80;
		endcase
	endfunction

	function automatic logic [63:0] pick_map(input logic [63:0] dflt);
		case ($urandom_range(0, 3))
			0: return dflt;
			1: return '0;
			2: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic reset_predictor();
		cfg_pattern  = '0;
		cfg_len      = LEN_W'(1);
		cfg_case     = 1'b0;
		cfg_whole    = 1'b0;
		cfg_word_map = {128'd0, WORD_MAP_1_RST, WORD_MAP_0_RST};
		foreach (win_bytes[k]) win_bytes[k] = '0;
		skip_left    = 0;
		col_count    = 0;
		line_count   = LINE_W'(1);
		cand_waiting = 1'b0;
		cand_col     = 0;
		match_count  = '0;
	endtask

	task automatic log_match(input int unsigned column);
		match_rec_t rec;
		if (match_count != TOTAL_SAT) begin
			match_count++;
		end
		rec = '{line_count, COL_W'(column), match_count};
		expected_matches = {expected_matches, rec};
	endtask

	task automatic scan_text_word(input logic [7:0] b, input logic eol);
		int unsigned n;
		int unsigned c;
		int unsigned start;
		bit reported;
		bit hit;
		n = eff_len();
		reported = 1'b0;
		// A candidate that waited for its right neighbour is settled first.
		if (cand_waiting) begin
			cand_waiting = 1'b0;
			if (eol || !cfg_whole || !is_word_char(b)) begin
				log_match(cand_col);
				reported = 1'b1;
			end
		end
		if (eol) begin
			foreach (win_bytes[k]) win_bytes[k] = '0;
			skip_left = 0;
			col_count = 0;
			if (line_count != LINE_SAT) begin
				line_count++;
			end
		end else begin
			for (int k = WIN_DEPTH - 1; k > 0; k--) begin
				win_bytes[k] = win_bytes[k-1];
			end
			win_bytes[0] = b;
			c = col_count;
			if (skip_left != 0) begin
				skip_left--;
			end else if (c + 1 >= n) begin
				hit = 1'b1;
				for (int i = 0; i < n; i++) begin
					if (fold_case(cfg_pattern[8*i +: 8]) != fold_case(win_bytes[n-1-i])) begin
						hit = 1'b0;
					end
				end
				if (hit) begin
					start = c - (n - 1);
					skip_left = n - 1;
					if (cfg_whole) begin
						if (start == 0 || !is_word_char(win_bytes[n])) begin
							cand_waiting = 1'b1;
							cand_col = start;
						end
					end else if (!reported) begin
						log_match(start);
					end else begin
						cand_waiting = 1'b1;
						cand_col = start;
					end
				end
			end
			if (c < COL_LIMIT) begin
				col_count = c + 1;
			end
		end
	endtask

	// Writes stay asserted back to back; finish_writes lowers the enable.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_PATTERN:    cfg_pattern = data;
			REG_PAT_LEN:    cfg_len = data[LEN_W-1:0];
			REG_MATCH_CASE: cfg_case = data[0];
			REG_WHOLE_WORD: cfg_whole = data[0];
			REG_WORD_MAP_0: cfg_word_map[63:0] = data;
			REG_WORD_MAP_1: cfg_word_map[127:64] = data;
			REG_WORD_MAP_2: cfg_word_map[191:128] = data;
			REG_WORD_MAP_3: cfg_word_map[255:192] = data;
			default: ;
		endcase
	endtask

	task automatic finish_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_count++;
	endtask

	task automatic load_settings(input logic [63:0] pat, input logic [3:0] len,
			input logic exact, input logic whole, input logic [255:0] maps);
		write_reg(REG_PATTERN, pat);
		write_reg(REG_PAT_LEN, 64'(len));
		write_reg(REG_MATCH_CASE, 64'(exact));
		write_reg(REG_WHOLE_WORD, 64'(whole));
		write_reg(REG_WORD_MAP_0, maps[63:0]);
		write_reg(REG_WORD_MAP_1, maps[127:64]);
		write_reg(REG_WORD_MAP_2, maps[191:128]);
		write_reg(REG_WORD_MAP_3, maps[255:192]);
		// Indexes past the last register must leave everything unchanged.
		write_reg(REG_WORD_MAP_3 + CFG_IDX_W'($urandom_range(1, 8)), {$urandom, $urandom});
		finish_writes();
	endtask

	task automatic wait_idle();
		while (text_queue.size() != 0 || text_ch.valid) @(posedge clk);
		while (expected_matches.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b);
		text_word_t w;
		w = '{b, 1'b0};
		text_queue = {text_queue, w};
	endtask

	task automatic push_eol();
		text_word_t w;
		w = '{8'($urandom_range(0, 255)), 1'b1};
		text_queue = {text_queue, w};
	endtask

	task automatic push_text(input string s);
		foreach (s[i]) push_byte(s[i]);
	endtask

	// Lines built mostly from pattern copies, with flipped case, broken copies
	// and noise between them.
	task automatic gen_lines(input int want);
		int made;
		int n;
		int cut;
		int bad;
		logic [7:0] b;
		made = 0;
		while (made < want) begin
			repeat ($urandom_range(0, 10)) begin
				n = eff_len();
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 8: begin
						cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : n;
						bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cut - 1) : -1;
						for (int i = 0; i < cut; i++) begin
							b = cfg_pattern[8*i +: 8];
							if ($urandom_range(0, 1)) begin
								b = flip_case(b);
							end
							if (i == bad) begin
								b = pick_char();
							end
							push_byte(b);
							made++;
						end
					end
					4, 5: begin
						push_byte($urandom_range(0, 1) ? " " : "-");
						made++;
					end
					6, 9: begin
						push_byte(pick_char());
						made++;
					end
					default: begin
						push_byte(8'($urandom_range(0, 255)));
						made++;
					end
				endcase
			end
			push_eol();
			made++;
		end
	endtask

	// Driver: a new word is offered once the previous one has been taken.
	always @(negedge clk) begin : drive_text
		text_word_t nxt;
		if (!text_ch.valid || text_fire) begin
			if (text_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = text_queue[0];
				text_queue.delete(0);
				text_ch.valid     <= 1'b1;
				text_ch.text_byte <= nxt.text_byte;
				text_ch.line_end  <= nxt.line_end;
			end else begin
				text_ch.valid <= 1'b0;
			end
		end
		match_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Monitor: predicts on every taken text word and checks every taken match.
	always @(posedge clk) begin : watch_ports
		match_rec_t want;
		text_fire = text_ch.valid && text_ch.ready;
		if (text_fire) begin
			words_taken++;
			scan_text_word(text_ch.text_byte, text_ch.line_end);
		end
		if (match_ch.valid && match_ch.ready) begin
			if (expected_matches.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("unexpected match: line %0d column %0d total %0d",
						match_ch.match_line, match_ch.match_column, match_ch.match_total);
				end
			end else begin
				want = expected_matches[0];
				expected_matches.delete(0);
				matches_checked++;
				if (match_ch.match_line !== want.line_no || match_ch.match_column !== want.column
						|| match_ch.match_total !== want.total) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("match mismatch: expected line %0d column %0d total %0d, got %0d %0d %0d",
							want.line_no, want.column, want.total, match_ch.match_line,
							match_ch.match_column, match_ch.match_total);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((text_ch.valid && text_ch.ready) || (match_ch.valid && match_ch.ready) || cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_whole_word_substring_matcher failed");
			$finish;
		end
	end

	initial begin
		logic [255:0] dflt_maps;
		int mode;
		dflt_maps = {128'd0, WORD_MAP_1_RST, WORD_MAP_0_RST};
		reset_predictor();
		error_count = 0;
		words_taken = 0;
		matches_checked = 0;
		settings_count = 0;
		idle_cycles = 0;
		text_fire = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = '0;
		text_ch.line_end = 1'b0;
		match_ch.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a one-byte pattern of 0x00, with byte extremes.
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_eol();
		wait_idle();

		// Folded "aB" as a whole word: line start, right and left word rejects,
		// line end as neighbour, and a candidate left waiting at the end.
		load_settings(64'h4261, 4'd2, 1'b0, 1'b1, dflt_maps);
		push_text("AB-xab abc ab");
		push_eol();
		push_text("ab");
		wait_idle();

		// Clearing whole_word under the waiting candidate reports it with the next word.
		write_reg(REG_WHOLE_WORD, 64'd0);
		write_reg(REG_PAT_LEN, 64'd1);
		finish_writes();
		push_text("ab");
		push_eol();
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			mode = ph % 4;
			if (ph == 0) begin
				load_settings('1, 4'd15, 1'b0, 1'b1, '1);
			end else if (ph == 1) begin
				load_settings('0, 4'd0, 1'b1, 1'b1, '0);
			end else begin
				load_settings({pick_char(), pick_char(), pick_char(), pick_char(),
						pick_char(), pick_char(), pick_char(), pick_char()},
					($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(1, 8)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					{pick_map('0), pick_map('0), pick_map(WORD_MAP_1_RST),
						pick_map(WORD_MAP_0_RST)});
			end
			send_idle_pct = idle_send_tab[mode];
			stall_pct = idle_stall_tab[mode];
			gen_lines(PHASE_WORDS);
			wait_idle();
		end

		error_count += expected_matches.size();
		$display("Sent %0d text words under %0d register settings and all idle mixes.",
			words_taken, settings_count);
		$display("Checked %0d matches; %0d mismatches.", matches_checked, error_count);
		if (error_count == 0) begin
			$display("tb_whole_word_substring_matcher passed");
		end else begin
			$display("tb_whole_word_substring_matcher failed");
		end
		$finish;
	end

endmodule
